/* rtl/core/gbms_pkg.sv */
// types, constants and helpers shared by the backlash sequencer modules
`timescale 1ns / 1ps

package gbms_pkg;

  localparam int MaxSamples = 4096;
  localparam int CntW       = $clog2(MaxSamples + 1);
  localparam int AngW       = 20;
  localparam int SumW       = 32;
  localparam int DivSteps   = SumW;
  localparam int StepW      = $clog2(DivSteps);
  localparam int CfgIdxW    = 3;
  localparam int CfgDataW   = 20;
  localparam int LimW       = 19;
  localparam int ThrW       = 20;
  localparam int SecW       = 8;

  localparam logic [SecW-1:0] FwdSecReset = 8'd5;
  localparam logic [SecW-1:0] WaitSecReset = 8'd2;
  localparam logic [SecW-1:0] RevSecReset = 8'd5;
  localparam logic [LimW-1:0] LimitReset = 19'd2560;
  localparam logic [ThrW-1:0] ThreshReset = 20'd1024;

  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_STOP   = 2'd1,
    OP_TICK   = 2'd2,
    OP_SAMPLE = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_FORWARD = 3'd1,
    PH_CALIB   = 3'd2,
    PH_WAIT    = 3'd3,
    PH_REVERSE = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_ACCEPT = 3'd1,
    EV_REJECT = 3'd2,
    EV_CALIB  = 3'd3,
    EV_DONE   = 3'd4,
    EV_FULL   = 3'd5
  } event_t;

  typedef enum logic [2:0] {
    CFG_FWD_SEC  = 3'd0,
    CFG_WAIT_SEC = 3'd1,
    CFG_REV_SEC  = 3'd2,
    CFG_LIMIT    = 3'd3,
    CFG_THRESH   = 3'd4
  } cfg_idx_t;

  typedef enum logic [1:0] {
    SQ_IDLE,
    SQ_DIV_GO,
    SQ_DIV_WAIT,
    SQ_EMIT
  } seq_state_t;

  typedef struct packed {
    logic                   start;
    logic signed [SumW-1:0] dividend;
    logic [CntW-1:0]        divisor;
  } div_req_t;

  typedef struct packed {
    logic                   done;
    logic signed [AngW-1:0] quotient;
  } div_rsp_t;

  function automatic logic [AngW-1:0] mag20(input logic signed [AngW-1:0] v);
    mag20 = v[AngW-1] ? AngW'(-v) : AngW'(v);
  endfunction

endpackage

/* rtl/core/gear_backlash_measurement_sequencer_unit.sv */
// gear backlash test sequencer: phase control, sample statistics, backlash result
//
//   channel  signals                                   role
//   in       in_valid/in_ready, opcode, sample_angle   commands, ticks, samples
//   out      out_valid/out_ready, 12 result fields     one word per input word
//   cfg      cfg_we, cfg_index, cfg_wdata              five timing/limit registers
//
// start/stop/tick and non-accepted samples: SQ_IDLE -> SQ_EMIT, which loads the result word.
// an accepted sample: SQ_DIV_GO, then SQ_DIV_WAIT until the 32-step serial divider
// for the mean is done, then SQ_EMIT.
// in_ready is low from accept until the result word is loaded into the output register.
// a word waiting on out_ready does not hold off the next input word.
// rst_n is synchronous; no clearing pass is needed.
`timescale 1ns / 1ps

module gear_backlash_measurement_sequencer_unit
  import gbms_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [1:0]             in_opcode,
  input  logic signed [AngW-1:0] in_sample_angle,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [2:0]             out_phase,
  output logic [SecW-1:0]        out_countdown,
  output logic [2:0]             out_event_code,
  output logic [CntW-1:0]        out_sample_count,
  output logic [LimW-1:0]        out_max_forward,
  output logic signed [AngW-1:0] out_max_reverse,
  output logic signed [AngW-1:0] out_avg_forward,
  output logic signed [AngW-1:0] out_avg_reverse,
  output logic [AngW-1:0]        out_backlash_max,
  output logic [AngW:0]          out_backlash_avg,
  output logic                   out_max_excessive,
  output logic                   out_avg_excessive,
  input  logic                   cfg_we,
  input  logic [CfgIdxW-1:0]     cfg_index,
  input  logic [CfgDataW-1:0]    cfg_wdata
);

  // configuration
  logic [SecW-1:0] fwd_sec_r, wait_sec_r, rev_sec_r;
  logic [LimW-1:0] limit_r;
  logic [ThrW-1:0] thresh_r;

  // sequencer and statistics
  seq_state_t             sq_r, sq_nxt;
  phase_t                 phase_r, phase_nxt;
  event_t                 ev_r, ev_nxt;
  logic [SecW-1:0]        ticks_r, ticks_nxt;
  logic signed [SumW-1:0] fsum_r, fsum_nxt, rsum_r, rsum_nxt;
  logic [CntW-1:0]        fcnt_r, fcnt_nxt, rcnt_r, rcnt_nxt;
  logic [LimW-1:0]        fpeak_r, fpeak_nxt;
  logic signed [AngW-1:0] rpeak_r, rpeak_nxt;
  logic signed [AngW-1:0] fmean_r, fmean_nxt, rmean_r, rmean_nxt;
  logic [AngW-1:0]        pbl_r, pbl_nxt;
  logic [AngW:0]          mbl_r, mbl_nxt;
  logic                   rev_begun_r, rev_begun_nxt;
  logic                   fmax_r, fmax_nxt, favg_r, favg_nxt;
  logic                   out_valid_r, out_valid_nxt;

  div_req_t        dreq;
  div_rsp_t        drsp;
  logic            accept;
  logic            load_out;
  logic [AngW-1:0] amag;
  logic [AngW:0]   peak_sum, mean_sum;

  gbms_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (dreq),
    .rsp  (drsp)
  );

  assign in_ready = (sq_r == SQ_IDLE);
  assign accept   = in_valid && in_ready;
  assign amag     = mag20(in_sample_angle);
  assign peak_sum = {1'b0, AngW'(fpeak_r)} + {1'b0, mag20(rpeak_r)};
  assign mean_sum = {1'b0, mag20(fmean_r)} + {1'b0, mag20(rmean_r)};

  assign dreq.start    = (sq_r == SQ_DIV_GO);
  assign dreq.dividend = (phase_r == PH_REVERSE) ? rsum_r : fsum_r;
  assign dreq.divisor  = (phase_r == PH_REVERSE) ? rcnt_r : fcnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_sec_r  <= FwdSecReset;
      wait_sec_r <= WaitSecReset;
      rev_sec_r  <= RevSecReset;
      limit_r    <= LimitReset;
      thresh_r   <= ThreshReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_FWD_SEC:  fwd_sec_r  <= cfg_wdata[SecW-1:0];
        CFG_WAIT_SEC: wait_sec_r <= cfg_wdata[SecW-1:0];
        CFG_REV_SEC:  rev_sec_r  <= cfg_wdata[SecW-1:0];
        CFG_LIMIT:    limit_r    <= cfg_wdata[LimW-1:0];
        CFG_THRESH:   thresh_r   <= cfg_wdata[ThrW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_r        <= SQ_IDLE;
      phase_r     <= PH_IDLE;
      ev_r        <= EV_NONE;
      ticks_r     <= '0;
      fsum_r      <= '0;
      rsum_r      <= '0;
      fcnt_r      <= '0;
      rcnt_r      <= '0;
      fpeak_r     <= '0;
      rpeak_r     <= '0;
      fmean_r     <= '0;
      rmean_r     <= '0;
      pbl_r       <= '0;
      mbl_r       <= '0;
      rev_begun_r <= 1'b0;
      fmax_r      <= 1'b0;
      favg_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      sq_r        <= sq_nxt;
      phase_r     <= phase_nxt;
      ev_r        <= ev_nxt;
      ticks_r     <= ticks_nxt;
      fsum_r      <= fsum_nxt;
      rsum_r      <= rsum_nxt;
      fcnt_r      <= fcnt_nxt;
      rcnt_r      <= rcnt_nxt;
      fpeak_r     <= fpeak_nxt;
      rpeak_r     <= rpeak_nxt;
      fmean_r     <= fmean_nxt;
      rmean_r     <= rmean_nxt;
      pbl_r       <= pbl_nxt;
      mbl_r       <= mbl_nxt;
      rev_begun_r <= rev_begun_nxt;
      fmax_r      <= fmax_nxt;
      favg_r      <= favg_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    sq_nxt        = sq_r;
    phase_nxt     = phase_r;
    ev_nxt        = ev_r;
    ticks_nxt     = ticks_r;
    fsum_nxt      = fsum_r;
    rsum_nxt      = rsum_r;
    fcnt_nxt      = fcnt_r;
    rcnt_nxt      = rcnt_r;
    fpeak_nxt     = fpeak_r;
    rpeak_nxt     = rpeak_r;
    fmean_nxt     = fmean_r;
    rmean_nxt     = rmean_r;
    pbl_nxt       = pbl_r;
    mbl_nxt       = mbl_r;
    rev_begun_nxt = rev_begun_r;
    fmax_nxt      = fmax_r;
    favg_nxt      = favg_r;
    load_out      = 1'b0;

    unique case (sq_r)
      SQ_IDLE: begin
        if (accept) begin
          ev_nxt = EV_NONE;
          sq_nxt = SQ_EMIT;
          unique case (op_t'(in_opcode))
            OP_START: begin
              if (phase_r == PH_IDLE) begin
                fsum_nxt      = '0;
                rsum_nxt      = '0;
                fcnt_nxt      = '0;
                rcnt_nxt      = '0;
                fpeak_nxt     = '0;
                rpeak_nxt     = '0;
                fmean_nxt     = '0;
                rmean_nxt     = '0;
                pbl_nxt       = '0;
                mbl_nxt       = '0;
                rev_begun_nxt = 1'b0;
                fmax_nxt      = 1'b0;
                favg_nxt      = 1'b0;
                phase_nxt     = PH_FORWARD;
                ticks_nxt     = fwd_sec_r;
              end
            end
            OP_STOP: begin
              phase_nxt = PH_IDLE;
            end
            OP_TICK: begin
              if (phase_r == PH_CALIB) begin
                phase_nxt = PH_WAIT;
                ticks_nxt = wait_sec_r;
              end else if (phase_r != PH_IDLE) begin
                if (ticks_r > SecW'(1)) begin
                  ticks_nxt = ticks_r - SecW'(1);
                end else begin
                  ticks_nxt = '0;
                  priority if (phase_r == PH_FORWARD) begin
                    phase_nxt = PH_CALIB;
                    ev_nxt    = EV_CALIB;
                  end else if (phase_r == PH_WAIT) begin
                    phase_nxt     = PH_REVERSE;
                    ticks_nxt     = rev_sec_r;
                    rpeak_nxt     = '0;
                    rsum_nxt      = '0;
                    rcnt_nxt      = '0;
                    rmean_nxt     = '0;
                    rev_begun_nxt = 1'b1;
                  end else begin
                    // end of reverse phase: backlash and flags
                    pbl_nxt   = peak_sum[AngW-1:0];
                    mbl_nxt   = mean_sum;
                    fmax_nxt  = peak_sum > {1'b0, thresh_r};
                    favg_nxt  = mean_sum > {1'b0, thresh_r};
                    phase_nxt = PH_IDLE;
                    ev_nxt    = EV_DONE;
                  end
                end
              end
            end
            OP_SAMPLE: begin
              if (phase_r == PH_FORWARD || phase_r == PH_REVERSE) begin
                if (amag > {1'b0, limit_r}) begin
                  ev_nxt = EV_REJECT;
                end else if (phase_r == PH_FORWARD) begin
                  if (fcnt_r >= CntW'(MaxSamples)) begin
                    ev_nxt = EV_FULL;
                  end else begin
                    ev_nxt   = EV_ACCEPT;
                    sq_nxt   = SQ_DIV_GO;
                    fsum_nxt = fsum_r + SumW'(in_sample_angle);
                    fcnt_nxt = fcnt_r + CntW'(1);
                    if (!in_sample_angle[AngW-1] && in_sample_angle[LimW-1:0] > fpeak_r) begin
                      fpeak_nxt = in_sample_angle[LimW-1:0];
                    end
                  end
                end else begin
                  if (rcnt_r >= CntW'(MaxSamples)) begin
                    ev_nxt = EV_FULL;
                  end else begin
                    ev_nxt   = EV_ACCEPT;
                    sq_nxt   = SQ_DIV_GO;
                    rsum_nxt = rsum_r + SumW'(in_sample_angle);
                    rcnt_nxt = rcnt_r + CntW'(1);
                    if (amag > mag20(rpeak_r)) begin
                      rpeak_nxt = in_sample_angle;
                    end
                  end
                end
              end
            end
            default: ;
          endcase
        end
      end
      SQ_DIV_GO: begin
        sq_nxt = SQ_DIV_WAIT;
      end
      SQ_DIV_WAIT: begin
        if (drsp.done) begin
          if (phase_r == PH_REVERSE) begin
            rmean_nxt = drsp.quotient;
          end else begin
            fmean_nxt = drsp.quotient;
          end
          sq_nxt = SQ_EMIT;
        end
      end
      SQ_EMIT: begin
        // wait for the output register to be free
        if (!out_valid_r || out_ready) begin
          load_out = 1'b1;
          sq_nxt   = SQ_IDLE;
        end
      end
      default: sq_nxt = SQ_IDLE;
    endcase

    out_valid_nxt = load_out || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_phase         <= phase_r;
      out_countdown     <= ticks_r;
      out_event_code    <= ev_r;
      out_sample_count  <= (phase_r == PH_REVERSE || (phase_r == PH_IDLE && rev_begun_r))
                           ? rcnt_r : fcnt_r;
      out_max_forward   <= fpeak_r;
      out_max_reverse   <= rpeak_r;
      out_avg_forward   <= fmean_r;
      out_avg_reverse   <= rmean_r;
      out_backlash_max  <= pbl_r;
      out_backlash_avg  <= mbl_r;
      out_max_excessive <= fmax_r;
      out_avg_excessive <= favg_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* rtl/core/gbms_div.sv */
// restoring divider for the running mean, one quotient bit per cycle
`timescale 1ns / 1ps

module gbms_div
  import gbms_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic              neg_r, neg_nxt;
  logic [StepW-1:0]  step_r, step_nxt;
  logic [SumW-1:0]   work_r, work_nxt;
  logic [CntW-1:0]   rem_r, rem_nxt;
  logic [CntW-1:0]   dvs_r, dvs_nxt;
  logic [CntW:0]     trial;
  logic [CntW:0]     diff;
  logic [AngW-1:0]   q_low;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    neg_r  <= neg_nxt;
    step_r <= step_nxt;
    work_r <= work_nxt;
    rem_r  <= rem_nxt;
    dvs_r  <= dvs_nxt;
  end

  assign trial = {rem_r, work_r[SumW-1]};
  assign diff  = trial - {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    neg_nxt  = neg_r;
    step_nxt = step_r;
    work_nxt = work_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      neg_nxt  = req.dividend[SumW-1];
      work_nxt = req.dividend[SumW-1] ? SumW'(-req.dividend) : SumW'(req.dividend);
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
      step_nxt = '0;
    end else if (busy_r) begin
      // shift in the next dividend bit, keep the difference when it fits
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt  = diff[CntW-1:0];
        work_nxt = {work_r[SumW-2:0], 1'b1};
      end else begin
        rem_nxt  = trial[CntW-1:0];
        work_nxt = {work_r[SumW-2:0], 1'b0};
      end
      step_nxt = step_r + StepW'(1);
      if (step_r == StepW'(DivSteps - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  assign q_low        = work_r[AngW-1:0];
  assign rsp.done     = done_r;
  assign rsp.quotient = neg_r ? AngW'(-q_low) : AngW'(q_low);

endmodule
